[sv/gravity_acceleration_sum_assert.svh]
// Assertion macros for the gravity acceleration sum checker.
// Each macro expects clk and rst_n to be visible in the scope where it is used.
`ifndef GRAVITY_ACCELERATION_SUM_ASSERT_SVH
`define GRAVITY_ACCELERATION_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GAS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gravity_acceleration_sum assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gravity_acceleration_sum assertion failed");

`endif

[sv/gas_pkg.sv]
// Package for the gravity acceleration sum block: widths, register indexes,
// limits, the state type and the control struct. Depends on nothing.
package gas_pkg;

    localparam int POS_W  = 40;
    localparam int DIFF_W = 41;
    localparam int MASS_W = 48;
    localparam int GRAV_W = 32;
    localparam int MPU_W  = 20;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;
    localparam int OUT_W  = 48;
    localparam int SUM_W  = 56;
    localparam int SQ_W   = 82;
    localparam int GM_W   = 80;
    localparam int M2_W   = 40;
    localparam int RAD_W  = 146;
    localparam int ROOT_W = 73;
    localparam int REM_W  = 76;
    localparam int P1_W   = 122;
    localparam int NUM_W  = 120;
    localparam int DEN_W  = 195;
    localparam int DREM_W = 196;
    localparam int QUO_W  = 56;
    localparam int CNT_W  = 7;
    localparam int COMP_W = 2;

    localparam int SQ_STEPS   = 40;
    localparam int GM_STEPS   = 32;
    localparam int ROOT_STEPS = 73;
    localparam int M2_STEPS   = 40;
    localparam int NUM_STEPS  = 40;
    localparam int DEN_STEPS  = 73;
    localparam int QUO_STEPS  = 56;

    localparam logic [IDX_W-1:0] REG_GRAV_CONSTANT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_METRES_PER_UNIT = 2'd1;

    localparam logic [GRAV_W-1:0] GRAV_RESET = 32'd66740000;
    localparam logic [MPU_W-1:0]  MPU_RESET  = 20'd1000;

    localparam logic [COMP_W-1:0] COMP_X = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
    localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 56'sh7F_FFFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 56'sh80_0000_0000_0000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DENOM,
        ST_DIV_CHECK,
        ST_DIV,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic ready;
        logic take;
        logic sq_step;
        logic root_step;
        logic den_step;
        logic div_check;
        logic div_step;
        logic accum;
        logic emit;
    } ctrl_t;

endpackage

[sv/gravity_acceleration_sum.sv]
// Top level of the gravity acceleration sum block: a bit-per-cycle datapath
// and its sequencer. Depends on gas_pkg.
//
// Each input transaction on in_valid/in_ready carries the target position,
// one attracting body's position and mass, and last_body. The block adds
// G*m*d/|d|^3 of that body to three running sums. On a transaction with
// last_body set, one output transaction on out_valid/out_ready carries the
// summed vector saturated to 48 bits, with coincidence and clip flags, and
// the sums clear. An ordinary body goes through accepting, squaring, square
// root and forming the denominator, then for each component a quotient check
// and a division on the shared restoring divider (the division is skipped
// when the quotient is clipped), and finishing. A body at zero distance
// goes from accepting straight to finishing. in_ready is high only while idle,
// so the next body can be accepted in the cycle right after a body finishes.
// The result sits in an output register and appears in the cycle after the last
// body finishes; a stalled receiver only holds the block in its finish step
// when the next result is ready before the pending one has been taken.
// Reset clears the sums and flags, empties the output register and loads
// the register defaults. Configuration writes take effect at the next edge.
module gravity_acceleration_sum #(
    parameter int ACCEL_FRAC_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gas_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gas_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [gas_pkg::POS_W-1:0]   target_x,
    input  logic signed [gas_pkg::POS_W-1:0]   target_y,
    input  logic signed [gas_pkg::POS_W-1:0]   target_z,
    input  logic signed [gas_pkg::POS_W-1:0]   other_x,
    input  logic signed [gas_pkg::POS_W-1:0]   other_y,
    input  logic signed [gas_pkg::POS_W-1:0]   other_z,
    input  logic [gas_pkg::MASS_W-1:0]         other_mass,
    input  logic                               last_body,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gas_pkg::OUT_W-1:0]   accel_x,
    output logic signed [gas_pkg::OUT_W-1:0]   accel_y,
    output logic signed [gas_pkg::OUT_W-1:0]   accel_z,
    output logic                               coincident_seen,
    output logic                               saturated
);

    // The numerator is G*m*|d| shifted left by the fraction bits plus the 32
    // fraction bits that the distance carries.
    localparam int SHIFT_W = ACCEL_FRAC_BITS + 32;
    localparam int NFULL_W = gas_pkg::NUM_W + SHIFT_W;
    localparam int HI_W    = NFULL_W - gas_pkg::QUO_W;

    gas_pkg::state_t state_reg, state_next;
    gas_pkg::ctrl_t  ctrl;

    logic [gas_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [gas_pkg::COMP_W-1:0] comp_reg;

    logic [gas_pkg::GRAV_W-1:0] grav_reg;
    logic [gas_pkg::MPU_W-1:0]  mpu_reg;

    logic signed [gas_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic zflag_reg;
    logic out_valid_reg;
    logic last_reg;

    logic signed [gas_pkg::OUT_W-1:0] accel_x_reg, accel_y_reg, accel_z_reg;
    logic coincident_reg, saturated_reg;

    // Per-body datapath registers.
    logic [gas_pkg::POS_W-1:0]  mag_x_reg, mag_y_reg, mag_z_reg;
    logic                       neg_x_reg, neg_y_reg, neg_z_reg;
    logic [gas_pkg::POS_W-1:0]  dsh_x_reg, dsh_y_reg, dsh_z_reg;
    logic [gas_pkg::MASS_W-1:0] mass_reg;
    logic [gas_pkg::GRAV_W-1:0] gsh_reg;
    logic [gas_pkg::GM_W-1:0]   gm_reg;
    logic [gas_pkg::SQ_W-1:0]   sq_reg;
    logic [gas_pkg::RAD_W-1:0]  rad_reg;
    logic [gas_pkg::ROOT_W-1:0] root_reg;
    logic [gas_pkg::REM_W-1:0]  rem_reg;
    logic [gas_pkg::M2_W-1:0]   m2sh_reg;
    logic [gas_pkg::P1_W-1:0]   p1_reg;
    logic [gas_pkg::NUM_W-1:0]  num_x_reg, num_y_reg, num_z_reg;
    logic [gas_pkg::DEN_W-1:0]  den_reg;
    logic [gas_pkg::DREM_W-1:0] drem_reg;
    logic [gas_pkg::QUO_W-1:0]  qsh_reg;

    // Combinational datapath signals.
    logic [gas_pkg::DIFF_W-1:0] diff_x, diff_y, diff_z;
    logic [gas_pkg::POS_W-1:0]  mag_x, mag_y, mag_z;
    logic                       is_zero;
    logic [gas_pkg::MPU_W-1:0]  mpu_eff;
    logic [gas_pkg::M2_W-1:0]   m2_prod;
    logic [gas_pkg::SQ_W-1:0]   sq_next;
    logic [gas_pkg::REM_W-1:0]  rem_shift, root_trial;
    logic                       root_ge;
    logic [gas_pkg::NUM_W-1:0]  num_sel;
    logic [NFULL_W-1:0]         num_full;
    logic [HI_W-1:0]            num_hi;
    logic [gas_pkg::DREM_W-1:0] hi_ext, den_ext, drem_shift;
    logic                       quo_ovf, div_ge;
    logic [gas_pkg::QUO_W-1:0]  qmag;
    logic                       neg_sel;
    logic signed [gas_pkg::SUM_W-1:0] sum_sel, sum_new;
    logic signed [gas_pkg::SUM_W:0]   contrib, sum_wide;
    logic                       out_free;
    logic [gas_pkg::OUT_W:0]    emit_x, emit_y, emit_z;

    // Clip a sum to the output width; the top bit of the result flags a clip.
    function automatic logic [gas_pkg::OUT_W:0] clip_out(
        input logic signed [gas_pkg::SUM_W-1:0] v);
        logic fits;
        fits = (v[gas_pkg::SUM_W-1:gas_pkg::OUT_W-1] == '0)
            || (v[gas_pkg::SUM_W-1:gas_pkg::OUT_W-1] == '1);
        if (fits)
        begin
            clip_out = {1'b0, v[gas_pkg::OUT_W-1:0]};
        end
        else if (v[gas_pkg::SUM_W-1])
        begin
            clip_out = {1'b1, gas_pkg::OUT_MIN};
        end
        else
        begin
            clip_out = {1'b1, gas_pkg::OUT_MAX};
        end
    endfunction

    // Position differences and their magnitudes; a difference of two 40-bit
    // values has a magnitude below 2^40.
    assign diff_x = {other_x[gas_pkg::POS_W-1], other_x}
                  - {target_x[gas_pkg::POS_W-1], target_x};
    assign diff_y = {other_y[gas_pkg::POS_W-1], other_y}
                  - {target_y[gas_pkg::POS_W-1], target_y};
    assign diff_z = {other_z[gas_pkg::POS_W-1], other_z}
                  - {target_z[gas_pkg::POS_W-1], target_z};

    assign mag_x = diff_x[gas_pkg::DIFF_W-1] ? gas_pkg::POS_W'(-diff_x)
                                             : diff_x[gas_pkg::POS_W-1:0];
    assign mag_y = diff_y[gas_pkg::DIFF_W-1] ? gas_pkg::POS_W'(-diff_y)
                                             : diff_y[gas_pkg::POS_W-1:0];
    assign mag_z = diff_z[gas_pkg::DIFF_W-1] ? gas_pkg::POS_W'(-diff_z)
                                             : diff_z[gas_pkg::POS_W-1:0];

    assign is_zero = (diff_x == '0) && (diff_y == '0) && (diff_z == '0);

    // A zero scale behaves as one metre per unit.
    assign mpu_eff = (mpu_reg == '0) ? gas_pkg::MPU_W'(1) : mpu_reg;
    assign m2_prod = gas_pkg::M2_W'(mpu_eff) * gas_pkg::M2_W'(mpu_eff);

    // Sum of squares, one bit of each magnitude per cycle, MSB first.
    assign sq_next = {sq_reg[gas_pkg::SQ_W-2:0], 1'b0}
        + (dsh_x_reg[gas_pkg::POS_W-1] ? gas_pkg::SQ_W'(mag_x_reg) : '0)
        + (dsh_y_reg[gas_pkg::POS_W-1] ? gas_pkg::SQ_W'(mag_y_reg) : '0)
        + (dsh_z_reg[gas_pkg::POS_W-1] ? gas_pkg::SQ_W'(mag_z_reg) : '0);

    // Restoring square root, two radicand bits in and one root bit out a cycle.
    assign rem_shift  = {rem_reg[gas_pkg::REM_W-3:0],
                         rad_reg[gas_pkg::RAD_W-1:gas_pkg::RAD_W-2]};
    assign root_trial = {1'b0, root_reg, 2'b01};
    assign root_ge    = rem_shift >= root_trial;

    // Divider operands for the component in work.
    always_comb
    begin
        case (comp_reg)
            gas_pkg::COMP_X:
            begin
                num_sel = num_x_reg;
                neg_sel = neg_x_reg;
                sum_sel = sum_x_reg;
            end
            gas_pkg::COMP_Y:
            begin
                num_sel = num_y_reg;
                neg_sel = neg_y_reg;
                sum_sel = sum_y_reg;
            end
            default:
            begin
                num_sel = num_z_reg;
                neg_sel = neg_z_reg;
                sum_sel = sum_z_reg;
            end
        endcase
    end

    assign num_full = {num_sel, SHIFT_W'(0)};
    assign num_hi   = num_full[NFULL_W-1:gas_pkg::QUO_W];
    assign hi_ext   = gas_pkg::DREM_W'(num_hi);
    assign den_ext  = {1'b0, den_reg};
    // If the bits above the quotient window already reach the divisor, the
    // quotient is at least 2^56 and is clipped without dividing.
    assign quo_ovf  = hi_ext >= den_ext;

    assign drem_shift = {drem_reg[gas_pkg::DREM_W-2:0], qsh_reg[gas_pkg::QUO_W-1]};
    assign div_ge     = drem_shift >= den_ext;

    // Contribution magnitude is clipped to the accumulator range, then signed.
    assign qmag     = qsh_reg[gas_pkg::QUO_W-1] ? gas_pkg::QUO_W'(gas_pkg::SUM_MAX) : qsh_reg;
    assign contrib  = neg_sel ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign sum_wide = $signed({sum_sel[gas_pkg::SUM_W-1], sum_sel}) + contrib;

    always_comb
    begin
        if (sum_wide[gas_pkg::SUM_W] != sum_wide[gas_pkg::SUM_W-1])
        begin
            sum_new = sum_wide[gas_pkg::SUM_W] ? gas_pkg::SUM_MIN : gas_pkg::SUM_MAX;
        end
        else
        begin
            sum_new = sum_wide[gas_pkg::SUM_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    assign emit_x = clip_out(sum_x_reg);
    assign emit_y = clip_out(sum_y_reg);
    assign emit_z = clip_out(sum_z_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = is_zero ? gas_pkg::ST_FINISH : gas_pkg::ST_SQUARE;
                end
            end
            gas_pkg::ST_SQUARE:
            begin
                if (cnt_reg == gas_pkg::CNT_W'(gas_pkg::SQ_STEPS - 1))
                begin
                    state_next = gas_pkg::ST_ROOT;
                end
            end
            gas_pkg::ST_ROOT:
            begin
                if (cnt_reg == gas_pkg::CNT_W'(gas_pkg::ROOT_STEPS - 1))
                begin
                    state_next = gas_pkg::ST_DENOM;
                end
            end
            gas_pkg::ST_DENOM:
            begin
                if (cnt_reg == gas_pkg::CNT_W'(gas_pkg::DEN_STEPS - 1))
                begin
                    state_next = gas_pkg::ST_DIV_CHECK;
                end
            end
            gas_pkg::ST_DIV_CHECK:
            begin
                state_next = quo_ovf ? gas_pkg::ST_ACCUM : gas_pkg::ST_DIV;
            end
            gas_pkg::ST_DIV:
            begin
                if (cnt_reg == gas_pkg::CNT_W'(gas_pkg::QUO_STEPS - 1))
                begin
                    state_next = gas_pkg::ST_ACCUM;
                end
            end
            gas_pkg::ST_ACCUM:
            begin
                state_next = (comp_reg == gas_pkg::COMP_Z) ? gas_pkg::ST_FINISH
                                                           : gas_pkg::ST_DIV_CHECK;
            end
            gas_pkg::ST_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = gas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gas_pkg::ST_IDLE;
            end
        endcase
    end

    // Step counter restarts on every change of state.
    always_comb
    begin
        if (state_next != state_reg)
        begin
            cnt_next = '0;
        end
        else
        begin
            case (state_reg)
                gas_pkg::ST_SQUARE, gas_pkg::ST_ROOT, gas_pkg::ST_DENOM, gas_pkg::ST_DIV:
                begin
                    cnt_next = cnt_reg + gas_pkg::CNT_W'(1);
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            gas_pkg::ST_IDLE:
            begin
                ctrl.ready = 1'b1;
                ctrl.take  = in_valid;
            end
            gas_pkg::ST_SQUARE:    ctrl.sq_step   = 1'b1;
            gas_pkg::ST_ROOT:      ctrl.root_step = 1'b1;
            gas_pkg::ST_DENOM:     ctrl.den_step  = 1'b1;
            gas_pkg::ST_DIV_CHECK: ctrl.div_check = 1'b1;
            gas_pkg::ST_DIV:       ctrl.div_step  = 1'b1;
            gas_pkg::ST_ACCUM:     ctrl.accum     = 1'b1;
            gas_pkg::ST_FINISH:    ctrl.emit      = last_reg && out_free;
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign in_ready = ctrl.ready;

    // Control state, configuration and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gas_pkg::ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= gas_pkg::COMP_X;
            grav_reg      <= gas_pkg::GRAV_RESET;
            mpu_reg       <= gas_pkg::MPU_RESET;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            zflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    gas_pkg::REG_GRAV_CONSTANT:   grav_reg <= cfg_data;
                    gas_pkg::REG_METRES_PER_UNIT: mpu_reg  <= cfg_data[gas_pkg::MPU_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (ctrl.take)
            begin
                last_reg <= last_body;
                comp_reg <= gas_pkg::COMP_X;
                if (is_zero)
                begin
                    zflag_reg <= 1'b1;
                end
            end

            if (ctrl.accum)
            begin
                case (comp_reg)
                    gas_pkg::COMP_X: sum_x_reg <= sum_new;
                    gas_pkg::COMP_Y: sum_y_reg <= sum_new;
                    default:         sum_z_reg <= sum_new;
                endcase
                comp_reg <= comp_reg + gas_pkg::COMP_W'(1);
            end

            if (ctrl.emit)
            begin
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                sum_z_reg     <= '0;
                zflag_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            accel_x_reg    <= emit_x[gas_pkg::OUT_W-1:0];
            accel_y_reg    <= emit_y[gas_pkg::OUT_W-1:0];
            accel_z_reg    <= emit_z[gas_pkg::OUT_W-1:0];
            coincident_reg <= zflag_reg;
            saturated_reg  <= emit_x[gas_pkg::OUT_W] | emit_y[gas_pkg::OUT_W]
                            | emit_z[gas_pkg::OUT_W];
        end
    end

    // Serial datapath.
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            mag_z_reg <= mag_z;
            dsh_x_reg <= mag_x;
            dsh_y_reg <= mag_y;
            dsh_z_reg <= mag_z;
            neg_x_reg <= diff_x[gas_pkg::DIFF_W-1];
            neg_y_reg <= diff_y[gas_pkg::DIFF_W-1];
            neg_z_reg <= diff_z[gas_pkg::DIFF_W-1];
            mass_reg  <= other_mass;
            gsh_reg   <= grav_reg;
            m2sh_reg  <= m2_prod;
            gm_reg    <= '0;
            sq_reg    <= '0;
            root_reg  <= '0;
            rem_reg   <= '0;
            p1_reg    <= '0;
            num_x_reg <= '0;
            num_y_reg <= '0;
            num_z_reg <= '0;
            den_reg   <= '0;
        end

        if (ctrl.sq_step)
        begin
            sq_reg <= sq_next;
            // G*m runs alongside, one bit of G a cycle.
            if (cnt_reg < gas_pkg::CNT_W'(gas_pkg::GM_STEPS))
            begin
                gm_reg  <= {gm_reg[gas_pkg::GM_W-2:0], 1'b0}
                         + (gsh_reg[gas_pkg::GRAV_W-1] ? gas_pkg::GM_W'(mass_reg) : '0);
                gsh_reg <= {gsh_reg[gas_pkg::GRAV_W-2:0], 1'b0};
            end
            if (cnt_reg == gas_pkg::CNT_W'(gas_pkg::SQ_STEPS - 1))
            begin
                // Reload the magnitudes for the numerator products.
                dsh_x_reg <= mag_x_reg;
                dsh_y_reg <= mag_y_reg;
                dsh_z_reg <= mag_z_reg;
                rad_reg   <= {sq_next, 64'b0};
            end
            else
            begin
                dsh_x_reg <= {dsh_x_reg[gas_pkg::POS_W-2:0], 1'b0};
                dsh_y_reg <= {dsh_y_reg[gas_pkg::POS_W-2:0], 1'b0};
                dsh_z_reg <= {dsh_z_reg[gas_pkg::POS_W-2:0], 1'b0};
            end
        end

        if (ctrl.root_step)
        begin
            rem_reg  <= root_ge ? rem_shift - root_trial : rem_shift;
            root_reg <= {root_reg[gas_pkg::ROOT_W-2:0], root_ge};
            rad_reg  <= {rad_reg[gas_pkg::RAD_W-3:0], 2'b00};
            // M^2 * s and the three numerator products share these cycles.
            if (cnt_reg < gas_pkg::CNT_W'(gas_pkg::M2_STEPS))
            begin
                p1_reg   <= {p1_reg[gas_pkg::P1_W-2:0], 1'b0}
                          + (m2sh_reg[gas_pkg::M2_W-1] ? gas_pkg::P1_W'(sq_reg) : '0);
                m2sh_reg <= {m2sh_reg[gas_pkg::M2_W-2:0], 1'b0};
            end
            if (cnt_reg < gas_pkg::CNT_W'(gas_pkg::NUM_STEPS))
            begin
                num_x_reg <= {num_x_reg[gas_pkg::NUM_W-2:0], 1'b0}
                           + (dsh_x_reg[gas_pkg::POS_W-1] ? gas_pkg::NUM_W'(gm_reg) : '0);
                num_y_reg <= {num_y_reg[gas_pkg::NUM_W-2:0], 1'b0}
                           + (dsh_y_reg[gas_pkg::POS_W-1] ? gas_pkg::NUM_W'(gm_reg) : '0);
                num_z_reg <= {num_z_reg[gas_pkg::NUM_W-2:0], 1'b0}
                           + (dsh_z_reg[gas_pkg::POS_W-1] ? gas_pkg::NUM_W'(gm_reg) : '0);
                dsh_x_reg <= {dsh_x_reg[gas_pkg::POS_W-2:0], 1'b0};
                dsh_y_reg <= {dsh_y_reg[gas_pkg::POS_W-2:0], 1'b0};
                dsh_z_reg <= {dsh_z_reg[gas_pkg::POS_W-2:0], 1'b0};
            end
        end

        if (ctrl.den_step)
        begin
            // Denominator M^2 * s * R, one root bit a cycle.
            den_reg  <= {den_reg[gas_pkg::DEN_W-2:0], 1'b0}
                      + (root_reg[gas_pkg::ROOT_W-1] ? gas_pkg::DEN_W'(p1_reg) : '0);
            root_reg <= {root_reg[gas_pkg::ROOT_W-2:0], 1'b0};
        end

        if (ctrl.div_check)
        begin
            if (quo_ovf)
            begin
                qsh_reg <= gas_pkg::SUM_MAX;
            end
            else
            begin
                drem_reg <= hi_ext;
                qsh_reg  <= num_full[gas_pkg::QUO_W-1:0];
            end
        end

        if (ctrl.div_step)
        begin
            // Dividend bits leave qsh at the top as quotient bits enter below.
            drem_reg <= div_ge ? drem_shift - den_ext : drem_shift;
            qsh_reg  <= {qsh_reg[gas_pkg::QUO_W-2:0], div_ge};
        end
    end

    assign out_valid       = out_valid_reg;
    assign accel_x         = accel_x_reg;
    assign accel_y         = accel_y_reg;
    assign accel_z         = accel_z_reg;
    assign coincident_seen = coincident_reg;
    assign saturated       = saturated_reg;

endmodule

[sv/gas_checker.sv]
// Port-level checker for the gravity acceleration sum block, bound to the top.
// Depends on gas_pkg and gravity_acceleration_sum_assert.svh.
`include "gravity_acceleration_sum_assert.svh"

module gas_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [gas_pkg::OUT_W-1:0] accel_x,
    input logic signed [gas_pkg::OUT_W-1:0] accel_y,
    input logic signed [gas_pkg::OUT_W-1:0] accel_z,
    input logic                             coincident_seen,
    input logic                             saturated
);

    // A stalled result holds.
    `GAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accel_x) && $stable(accel_y) && $stable(accel_z) && $stable(coincident_seen) && $stable(saturated))

    // A body is in work after its transaction, so the block is busy next cycle.
    `GAS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // A clipped result has at least one component at an output limit.
    `GAS_ASSERT_IMPL(a_sat_at_limit, out_valid && saturated, accel_x == gas_pkg::OUT_MAX || accel_x == gas_pkg::OUT_MIN || accel_y == gas_pkg::OUT_MAX || accel_y == gas_pkg::OUT_MIN || accel_z == gas_pkg::OUT_MAX || accel_z == gas_pkg::OUT_MIN)

    // A result is only loaded at the end of a body's work, never while idle.
    `GAS_ASSERT_IMPL(a_load_while_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind gravity_acceleration_sum gas_checker u_gas_checker (.*);
